/* src/swerm_pkg.sv */
`timescale 1ns / 1ps

package swerm_pkg;

   localparam int NUM_SLOTS   = 60;
   localparam int COUNT_WIDTH = 24;
   localparam int RATE_W      = 24;
   localparam int STAMP_W     = 32;

   localparam logic [STAMP_W-1:0] WINDOW_SECONDS = STAMP_W'(60);

   localparam int SHORT_SPAN    = 5;
   localparam int MEDIUM_SPAN   = 30;
   localparam int LONG_SPAN     = 60;
   localparam int NUM_GROUPS    = LONG_SPAN / SHORT_SPAN;
   localparam int MEDIUM_GROUPS = MEDIUM_SPAN / SHORT_SPAN;

   // sum widths
   localparam int SH_W = COUNT_WIDTH + $clog2(SHORT_SPAN);
   localparam int ME_W = COUNT_WIDTH + $clog2(MEDIUM_SPAN);
   localparam int LO_W = COUNT_WIDTH + $clog2(LONG_SPAN);

   // 30 = 2 * 15 and 60 = 4 * 15
   localparam int DIV_ODD        = 15;
   localparam int MEDIUM_PRE_SHR = 1;
   localparam int LONG_PRE_SHR   = 2;
   localparam int DV_W           = ME_W - MEDIUM_PRE_SHR;

   localparam int SHORT_SHIFT = $clog2(SHORT_SPAN);
   localparam int ODD_SHIFT   = $clog2(DIV_ODD);

   // reciprocals, rounded up, exact for every operand of the given width
   localparam longint unsigned MULT_FIVE =
      ((64'd1 << (SH_W + SHORT_SHIFT)) + 64'(SHORT_SPAN - 1)) / 64'(SHORT_SPAN);
   localparam longint unsigned MULT_FIFTEEN =
      ((64'd1 << (DV_W + ODD_SHIFT)) + 64'(DIV_ODD - 1)) / 64'(DIV_ODD);

   localparam int PS_W = 2 * SH_W + 1;
   localparam int PD_W = 2 * DV_W + 1;

   localparam logic [RATE_W-1:0]      RATE_MAX  = {RATE_W{1'b1}};
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

   localparam logic OP_RECORD = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   typedef struct packed {
      logic               opcode;
      logic [STAMP_W-1:0] now_seconds;
   } req_type;

   typedef struct packed {
      logic [RATE_W-1:0] rate_short;
      logic [RATE_W-1:0] rate_medium;
      logic [RATE_W-1:0] rate_long;
   } rsp_type;

   typedef struct packed {
      logic            valid;
      logic [SH_W-1:0] sum_five;
      logic [ME_W-1:0] sum_thirty;
      logic [LO_W-1:0] sum_sixty;
   } sums_type;

   typedef logic [COUNT_WIDTH-1:0] count_array_type [NUM_SLOTS];

   function automatic logic [RATE_W-1:0] rate_clip(input logic [63:0] v);
      logic [RATE_W-1:0] r;
      r = (v > 64'(RATE_MAX)) ? RATE_MAX : v[RATE_W-1:0];
      return r;
   endfunction

endpackage

/* src/swerm_slots.sv */
`timescale 1ns / 1ps

module swerm_slots
   import swerm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  req_type         req,
   output logic            snap_valid_ff,
   output count_array_type count_ff
);

   logic [STAMP_W-1:0] stamp_ff [NUM_SLOTS];
   logic [STAMP_W-1:0] stamp_in [NUM_SLOTS];
   count_array_type    count_in;
   logic [STAMP_W-1:0] limit;
   logic               hit;

   assign hit   = (stamp_ff[0] == req.now_seconds);
   assign limit = req.now_seconds - WINDOW_SECONDS;

   always_comb begin
      stamp_in = stamp_ff;
      count_in = count_ff;
      if (accept && req.opcode == OP_RECORD) begin
         if (hit) begin
            if (count_ff[0] != COUNT_MAX) begin
               count_in[0] = count_ff[0] + COUNT_WIDTH'(1);
            end
         end else begin
            for (int i = 1; i < NUM_SLOTS; i++) begin
               stamp_in[i] = stamp_ff[i-1];
               count_in[i] = count_ff[i-1];
            end
            stamp_in[0] = req.now_seconds;
            count_in[0] = COUNT_WIDTH'(1);
            // expiry of stale seconds
            if (req.now_seconds >= WINDOW_SECONDS) begin
               for (int i = 0; i < NUM_SLOTS; i++) begin
                  if (stamp_in[i] < limit) begin
                     stamp_in[i] = '0;
                     count_in[i] = '0;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         snap_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            stamp_ff[i] <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         snap_valid_ff <= accept;
         stamp_ff      <= stamp_in;
         count_ff      <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_new_second: assert property (@(posedge clock) disable iff (reset)
      !reset && accept && req.opcode == OP_RECORD && !hit
      |=> stamp_ff[0] == $past(req.now_seconds) && count_ff[0] == COUNT_WIDTH'(1))
      else $error("new second not loaded into newest slot");
   a_query_still: assert property (@(posedge clock) disable iff (reset)
      !reset && accept && req.opcode == OP_QUERY
      |=> $stable(count_ff[0]) && $stable(stamp_ff[0]) && $stable(count_ff[NUM_SLOTS-1]))
      else $error("query changed slot state");
`endif

endmodule

/* src/swerm_sum.sv */
`timescale 1ns / 1ps

module swerm_sum
   import swerm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            snap_valid,
   input  count_array_type count,
   output sums_type        sums_ff
);

   logic [SH_W-1:0] group_ff [NUM_GROUPS];
   logic [SH_W-1:0] group_in [NUM_GROUPS];
   logic            group_valid_ff;

   logic [SH_W-1:0] five_ff;
   logic [ME_W-1:0] lower_ff;
   logic [ME_W-1:0] upper_ff;
   logic [ME_W-1:0] lower_in;
   logic [ME_W-1:0] upper_in;
   logic            part_valid_ff;

   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         group_in[g] = '0;
         for (int k = 0; k < SHORT_SPAN; k++) begin
            group_in[g] = group_in[g] + SH_W'(count[g*SHORT_SPAN + k]);
         end
      end
   end

   always_comb begin
      lower_in = '0;
      upper_in = '0;
      for (int g = 0; g < MEDIUM_GROUPS; g++) begin
         lower_in = lower_in + ME_W'(group_ff[g]);
      end
      for (int g = MEDIUM_GROUPS; g < NUM_GROUPS; g++) begin
         upper_in = upper_in + ME_W'(group_ff[g]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_valid_ff <= 1'b0;
         part_valid_ff  <= 1'b0;
         sums_ff.valid  <= 1'b0;
      end else begin
         group_valid_ff <= snap_valid;
         part_valid_ff  <= group_valid_ff;
         sums_ff.valid  <= part_valid_ff;
      end
      group_ff           <= group_in;
      five_ff            <= group_ff[0];
      lower_ff           <= lower_in;
      upper_ff           <= upper_in;
      sums_ff.sum_five   <= five_ff;
      sums_ff.sum_thirty <= lower_ff;
      sums_ff.sum_sixty  <= LO_W'(lower_ff) + LO_W'(upper_ff);
   end

endmodule

/* src/swerm_div.sv */
`timescale 1ns / 1ps

module swerm_div
   import swerm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  sums_type sums,
   output logic     result_valid_ff,
   output rsp_type  result_ff
);

   logic [PS_W-1:0] prod_five_ff;
   logic [PD_W-1:0] prod_thirty_ff;
   logic [PD_W-1:0] prod_sixty_ff;
   logic            quiet_ff;
   logic            prod_valid_ff;

   logic [DV_W-1:0] half_thirty;
   logic [DV_W-1:0] quarter_sixty;

   logic [PS_W-1-(SH_W+SHORT_SHIFT):0] q_five;
   logic [PD_W-1-(DV_W+ODD_SHIFT):0]   q_thirty;
   logic [PD_W-1-(DV_W+ODD_SHIFT):0]   q_sixty;
   rsp_type                            result_in;

   assign half_thirty   = DV_W'(sums.sum_thirty >> MEDIUM_PRE_SHR);
   assign quarter_sixty = DV_W'(sums.sum_sixty >> LONG_PRE_SHR);

   assign q_five   = prod_five_ff[PS_W-1:SH_W+SHORT_SHIFT];
   assign q_thirty = prod_thirty_ff[PD_W-1:DV_W+ODD_SHIFT];
   assign q_sixty  = prod_sixty_ff[PD_W-1:DV_W+ODD_SHIFT];

   always_comb begin
      if (quiet_ff) begin
         result_in = '0;
      end else begin
         result_in.rate_short  = rate_clip(64'(q_five));
         result_in.rate_medium = rate_clip(64'(q_thirty));
         result_in.rate_long   = rate_clip(64'(q_sixty));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff   <= 1'b0;
         result_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff   <= sums.valid;
         result_valid_ff <= prod_valid_ff;
      end
      prod_five_ff   <= PS_W'(sums.sum_five) * PS_W'(MULT_FIVE);
      prod_thirty_ff <= PD_W'(half_thirty) * PD_W'(MULT_FIFTEEN);
      prod_sixty_ff  <= PD_W'(quarter_sixty) * PD_W'(MULT_FIFTEEN);
      quiet_ff       <= (sums.sum_five == '0);
      result_ff      <= result_in;
   end

endmodule

/* src/swerm_fifo.sv */
`timescale 1ns / 1ps

module swerm_fifo
   import swerm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   input  logic    pop,
   output logic    out_valid,
   output rsp_type out_data
);

   rsp_type               mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff;
   logic [FIFO_CNT_W-1:0] level_ff;

   assign out_valid = (level_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + FIFO_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_PTR_W'(1);
         end
         if (push && !pop) begin
            level_ff <= level_ff + FIFO_CNT_W'(1);
         end else if (pop && !push) begin
            level_ff <= level_ff - FIFO_CNT_W'(1);
         end
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* src/sliding_window_event_rate_meter.sv */
`timescale 1ns / 1ps
// channel   direction  handshake             payload
// req_      in         req_valid, req_stall  req_type: opcode, now_seconds
// rsp_      out        rsp_valid, rsp_stall  rsp_type: rate_short, rate_medium, rate_long
//
// one transaction per cycle in while req_stall is low; each result passes through
// the slot update, three adder stages, multiply and result stages
// results queue in an 8-entry buffer; req_stall rises once 8 are outstanding
// reset clears all slots to stamp 0, count 0

module sliding_window_event_rate_meter
   import swerm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   logic                  accept;
   logic                  pop;
   logic [FIFO_CNT_W-1:0] reserved_ff;
   logic                  snap_valid;
   count_array_type       counts;
   sums_type              sums;
   logic                  result_valid;
   rsp_type               result;

   assign req_stall = (reserved_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign accept    = req_valid && !req_stall;
   assign pop       = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         reserved_ff <= '0;
      end else if (accept && !pop) begin
         reserved_ff <= reserved_ff + FIFO_CNT_W'(1);
      end else if (pop && !accept) begin
         reserved_ff <= reserved_ff - FIFO_CNT_W'(1);
      end
   end

   swerm_slots u_slots (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .req           (req_payload),
      .snap_valid_ff (snap_valid),
      .count_ff      (counts)
   );

   swerm_sum u_sum (
      .clock      (clock),
      .reset      (reset),
      .snap_valid (snap_valid),
      .count      (counts),
      .sums_ff    (sums)
   );

   swerm_div u_div (
      .clock           (clock),
      .reset           (reset),
      .sums            (sums),
      .result_valid_ff (result_valid),
      .result_ff       (result)
   );

   swerm_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (result_valid),
      .push_data (result),
      .pop       (pop),
      .out_valid (rsp_valid),
      .out_data  (rsp_payload)
   );

`ifndef SYNTHESIS
   a_reserved_bound: assert property (@(posedge clock) disable iff (reset)
      reserved_ff <= FIFO_CNT_W'(FIFO_DEPTH))
      else $error("outstanding transaction count beyond buffer depth");
   a_rsp_backed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> reserved_ff != '0)
      else $error("result offered with no outstanding transaction");
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      result_valid |-> reserved_ff != '0)
      else $error("result produced with no outstanding transaction");
`endif

endmodule
